@@ rtl/core/cfe_pkg.sv @@
// Shared definitions for the CRC-16 command frame encoder.
// Request and status codes, the result job record and the CRC byte update.
// No dependencies.
`default_nettype none

package cfe_pkg;

  // Request type codes
  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_PAYLOAD = 2'd1;
  localparam logic [1:0] REQ_RESP    = 2'd2;

  // Response status codes
  localparam logic [1:0] STAT_ACK    = 2'd0;
  localparam logic [1:0] STAT_NACK   = 2'd1;
  localparam logic [1:0] STAT_UNEXP  = 2'd2;

  // Result kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_RESP  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ACK  = 1'b0;
  localparam logic CFG_NACK = 1'b1;

  // Frame constants
  localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND = 8'hBB;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'h0000;

  localparam int unsigned MAX_RES = 6;

  // Reset values of the code registers
  localparam logic [7:0] ACK_RESET  = 8'd121;
  localparam logic [7:0] NACK_RESET = 8'd31;

  // All results caused by one transaction
  typedef struct packed {
    logic                       kind;
    logic [1:0]                 status;
    logic [MAX_RES-1:0][7:0]    bytes;     // element 0 goes out first
    logic [2:0]                 last_idx;  // index of the final result
  } job_t;

  // CRC-16/XMODEM update by one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cfe_seq.sv @@
// Result sequencer: holds one transaction's results and issues them one per
// cycle, unless out_ready stalls, through a registered output stage. Depends on cfe_pkg.
`default_nettype none

module cfe_seq
  import cfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       job_load,
  input  wire job_t       job_in,
  output logic            job_free,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_result_kind,
  output logic [7:0]      out_out_byte,
  output logic [1:0]      out_resp_status,
  output logic            out_last
);

  logic       job_valid_r, job_valid_nxt;
  job_t       job_r;
  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       kind_r;
  logic [7:0] byte_r;
  logic [1:0] status_r;
  logic       last_r;
  logic       out_load;
  logic       at_last;

  // Move the current result into the output register when it is free
  assign out_load = job_valid_r && (!out_valid_r || out_ready);
  assign at_last  = (idx_r == job_r.last_idx);
  assign job_free = !job_valid_r || (out_load && at_last);

  // Job holding register and result index
  always_comb begin
    job_valid_nxt = job_valid_r;
    idx_nxt       = idx_r;
    if (job_load) begin
      job_valid_nxt = 1'b1;
      idx_nxt       = 3'd0;
    end else if (out_load && at_last) begin
      job_valid_nxt = 1'b0;
    end else if (out_load) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  // Output stage valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job_in;
    end
    if (out_load) begin
      kind_r   <= job_r.kind;
      byte_r   <= job_r.bytes[idx_r];
      status_r <= job_r.status;
      last_r   <= at_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_out_byte    = byte_r;
  assign out_resp_status = status_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

@@ rtl/core/crc16_command_frame_encoder.sv @@
// Top level of the CRC-16 command frame encoder and response sorter.
// Depends on cfe_pkg and cfe_seq.
//
//  channel | ports                                   | direction
//  in      | in_valid/in_ready, in_req_type .. data  | transactions in
//  out     | out_valid/out_ready, out_* fields       | results out, one a cycle
//  cfg     | cfg_we, cfg_index, cfg_wdata            | register writes
//
// A transaction is decoded and the frame state updated in the cycle it is
// accepted; its results (up to six) leave one per cycle from the output
// register while out_ready allows. The next transaction is taken in the
// cycle the last result enters the output register, or while none is held.
// Reset is synchronous, active low; an out_ready stall holds the output and job.
`default_nettype none

module crc16_command_frame_encoder
  import cfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire logic [7:0] in_cmd_code,
  input  wire logic [7:0] in_payload_len,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_result_kind,
  output logic [7:0]      out_out_byte,
  output logic [1:0]      out_resp_status,
  output logic            out_last,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  logic [7:0]  ack_code_r, nack_code_r;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        open_r, open_nxt;
  logic        accept;
  logic        job_free;
  logic        job_load;
  job_t        job;
  logic [15:0] crc_hdr, crc_pay;

  assign in_ready = job_free;
  assign accept   = in_valid && in_ready;

  // CRC of the header bytes and of the running frame with this payload byte
  assign crc_hdr = crc_byte(crc_byte(CRC_INIT, in_cmd_code), in_payload_len);
  assign crc_pay = crc_byte(crc_r, in_data_byte);

  // Decode one transaction into its result list and next frame state
  always_comb begin
    job          = '0;
    job_load     = 1'b0;
    crc_nxt      = crc_r;
    left_nxt     = left_r;
    open_nxt     = open_r;
    job.kind     = KIND_FRAME;
    job.status   = STAT_ACK;
    case (in_req_type)
      REQ_START: begin
        job_load     = 1'b1;
        job.bytes[0] = SYNC_FIRST;
        job.bytes[1] = SYNC_SECOND;
        job.bytes[2] = in_cmd_code;
        job.bytes[3] = in_payload_len;
        job.bytes[4] = crc_hdr[15:8];
        job.bytes[5] = crc_hdr[7:0];
        crc_nxt      = crc_hdr;
        if (in_payload_len == 8'd0) begin
          job.last_idx = 3'd5;
          left_nxt     = 8'd0;
          open_nxt     = 1'b0;
        end else begin
          job.last_idx = 3'd3;
          left_nxt     = in_payload_len;
          open_nxt     = 1'b1;
        end
      end
      REQ_PAYLOAD: begin
        // dropped when no frame is open
        if (open_r) begin
          job_load     = 1'b1;
          job.bytes[0] = in_data_byte;
          job.bytes[1] = crc_pay[15:8];
          job.bytes[2] = crc_pay[7:0];
          crc_nxt      = crc_pay;
          left_nxt     = left_r - 8'd1;
          if (left_r == 8'd1) begin
            job.last_idx = 3'd2;
            open_nxt     = 1'b0;
          end else begin
            job.last_idx = 3'd0;
          end
        end
      end
      REQ_RESP: begin
        job_load     = 1'b1;
        job.kind     = KIND_RESP;
        job.last_idx = 3'd0;
        if (in_data_byte == ack_code_r) begin
          job.status = STAT_ACK;
        end else if (in_data_byte == nack_code_r) begin
          job.status = STAT_NACK;
        end else begin
          job.status = STAT_UNEXP;
        end
      end
      default: begin
        // unused request code: no results, no state change
      end
    endcase
  end

  // Frame state, updated on accepted transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      left_r <= 8'd0;
      open_r <= 1'b0;
    end else if (accept) begin
      crc_r  <= crc_nxt;
      left_r <= left_nxt;
      open_r <= open_nxt;
    end
  end

  // Code registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_code_r  <= ACK_RESET;
      nack_code_r <= NACK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACK:  ack_code_r  <= cfg_wdata;
        CFG_NACK: nack_code_r <= cfg_wdata;
        default:  ack_code_r  <= ack_code_r;
      endcase
    end
  end

  cfe_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_load        (accept && job_load),
    .job_in          (job),
    .job_free        (job_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_out_byte    (out_out_byte),
    .out_resp_status (out_resp_status),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire
